FILE: rtl/core/huffman_code_table_bit_packer_macros.svh
// Assertion helpers for the code table bit packer.
// All checks are sampled on clk_i and are off while rst_ni is low.
`ifndef HUFFMAN_CODE_TABLE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_TABLE_BIT_PACKER_MACROS_SVH

// Same-cycle implication.
`define HCTBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hctbp: same-cycle check failed");

// Next-cycle implication.
`define HCTBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hctbp: next-cycle check failed");

`endif

FILE: rtl/core/hctbp_pkg.sv
`timescale 1ns / 1ps

package hctbp_pkg;

  // Fixed field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned LEN_IN_W = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IN_DATA_W = 48;

  // Accumulator: up to 7 pending bits plus one full code word
  localparam int unsigned PEND_W  = 7;
  localparam int unsigned PCNT_W  = 3;
  localparam int unsigned WORK_W  = WORD_W + PEND_W;
  localparam int unsigned TOTAL_W = 6;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENCODE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic mem_wr;      // write table entry from input
    logic lookup;      // read table entry for input symbol
    logic merge;       // join pending bits with looked-up code
    logic flush_load;  // move pending bits to work register, padded
    logic emit;        // push top byte of work register to output
    logic commit;      // leftover bits become pending bits
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sym_ok;      // input symbol is inside the table
    logic byte_ready;  // work register holds a full byte
    logic slot_free;   // output register can take a byte this cycle
  } status_t;

endpackage

FILE: rtl/core/hctbp_ctrl.sv
`timescale 1ns / 1ps

module hctbp_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [hctbp_pkg::ACT_W-1:0]    action_i,
  output logic                           in_ready_o,
  input  hctbp_pkg::status_t             status_i,
  output hctbp_pkg::cmd_t                cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            hctbp_pkg::ACT_LOAD: begin
              cmd_o.mem_wr = status_i.sym_ok;
            end
            hctbp_pkg::ACT_ENCODE: begin
              if (status_i.sym_ok) begin
                cmd_o.lookup = 1'b1;
                state_d      = ST_LOOKUP;
              end
            end
            hctbp_pkg::ACT_FLUSH: begin
              cmd_o.flush_load = 1'b1;
              state_d          = ST_EMIT;
            end
            default: begin
              // unknown action: dropped
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd_o.merge = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.byte_ready) begin
          cmd_o.emit = status_i.slot_free;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/hctbp_datapath.sv
`timescale 1ns / 1ps

module hctbp_datapath #(
  parameter int unsigned LenLimit    = 32,
  parameter int unsigned SymbolCount = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hctbp_pkg::cmd_t                   cmd_i,
  output hctbp_pkg::status_t                status_o,
  input  logic [hctbp_pkg::SYM_W-1:0]       symbol_i,
  input  logic [hctbp_pkg::WORD_W-1:0]      code_word_i,
  input  logic [hctbp_pkg::LEN_IN_W-1:0]    code_length_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [hctbp_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                              out_last_o
);

  localparam int unsigned IdxW   = $clog2(SymbolCount);
  localparam int unsigned LenW   = $clog2(LenLimit + 1);
  localparam int unsigned WorkW  = hctbp_pkg::WORK_W;
  localparam int unsigned TotW   = hctbp_pkg::TOTAL_W;
  localparam int unsigned PendW  = hctbp_pkg::PEND_W;
  localparam int unsigned PcntW  = hctbp_pkg::PCNT_W;
  localparam int unsigned ByteW  = hctbp_pkg::BYTE_W;
  localparam int unsigned WordW  = hctbp_pkg::WORD_W;
  localparam int unsigned SymW   = hctbp_pkg::SYM_W;
  localparam int unsigned LenInW = hctbp_pkg::LEN_IN_W;

  // Code table storage, no reset
  logic [LenLimit-1:0] bits_mem [SymbolCount];
  logic [LenW-1:0]     len_mem  [SymbolCount];
  logic [LenLimit-1:0] rd_bits_q;
  logic [LenW-1:0]     rd_len_q;

  logic [IdxW-1:0]     idx;
  logic [LenW-1:0]     len_clamp;
  logic [WordW:0]      mask_wide;
  logic [LenLimit-1:0] wr_bits;

  // Accumulator
  logic [WorkW-1:0] work_q, work_d;
  logic [TotW-1:0]  total_q, total_d;
  logic [PendW-1:0] pend_q, pend_d;     // pending bits, left-aligned
  logic [PcntW-1:0] pcnt_q, pcnt_d;
  logic [TotW-1:0]  total_sum;
  logic [TotW-1:0]  shift_amt;
  logic [WorkW-1:0] code_ext;
  logic [WorkW-1:0] merged;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  assign idx = symbol_i[IdxW-1:0];

  // Status
  assign status_o.sym_ok     = ({1'b0, symbol_i} < (SymW + 1)'(SymbolCount));
  assign status_o.byte_ready = (total_q >= TotW'(ByteW));
  assign status_o.slot_free  = !out_valid_q || out_ready_i;

  // Load path: clamp length, drop code bits above it
  assign len_clamp = (code_length_i > LenInW'(LenLimit)) ? LenW'(LenLimit)
                                                         : code_length_i[LenW-1:0];
  assign mask_wide = ((WordW + 1)'(1) << len_clamp) - (WordW + 1)'(1);
  assign wr_bits   = code_word_i[LenLimit-1:0] & mask_wide[LenLimit-1:0];

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      bits_mem[idx] <= wr_bits;
      len_mem[idx]  <= len_clamp;
    end
    if (cmd_i.lookup) begin
      rd_bits_q <= bits_mem[idx];
      rd_len_q  <= len_mem[idx];
    end
  end

  // Place code right below the pending bits, all left-aligned
  assign total_sum = TotW'(pcnt_q) + TotW'(rd_len_q);
  assign shift_amt = TotW'(WorkW) - total_sum;
  assign code_ext  = WorkW'(rd_bits_q);
  assign merged    = {pend_q, {WordW{1'b0}}} | (code_ext << shift_amt);

  // Accumulator and output next state
  always_comb begin
    work_d      = work_q;
    total_d     = total_q;
    pend_d      = pend_q;
    pcnt_d      = pcnt_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (cmd_i.flush_load) begin
      work_d  = {pend_q, {WordW{1'b0}}};
      total_d = (pcnt_q != '0) ? TotW'(ByteW) : '0;
    end
    if (cmd_i.merge) begin
      work_d  = merged;
      total_d = total_sum;
    end
    if (cmd_i.emit) begin
      work_d  = work_q << ByteW;
      total_d = total_q - TotW'(ByteW);
    end
    if (cmd_i.commit) begin
      pend_d = work_q[WorkW-1 -: PendW];
      pcnt_d = total_q[PcntW-1:0];
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = work_q[WorkW-1 -: ByteW];
      out_last_d  = (total_q < TotW'(2 * ByteW));
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= '0;
      total_q     <= '0;
      pend_q      <= '0;
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      work_q      <= work_d;
      total_q     <= total_d;
      pend_q      <= pend_d;
      pcnt_q      <= pcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/core/huffman_code_table_bit_packer.sv
// Load: the table entry is written and the block stays idle. Encode: a table
// read, a merge, then n output bytes (0 to 4), one byte per cycle from the emit
// loop while the output slot is free. Flush: pending bits move to the work
// register and go out as one zero-padded byte, if any. Backpressure stalls output.
// Reset (rst_ni low, async) clears the pending bits and control state;
// code table contents stay undefined until loaded.
`timescale 1ns / 1ps
`include "huffman_code_table_bit_packer_macros.svh"

module huffman_code_table_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // symbol [7:0], code_word [39:8], code_length [45:40], zero [47:46]
  input  logic [hctbp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action [1:0]
  input  logic [hctbp_pkg::ACT_W-1:0]        s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // out_byte [7:0]
  output logic [hctbp_pkg::BYTE_W-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready
);

  localparam int unsigned LenLimit = (MAX_CODE_LEN < hctbp_pkg::WORD_W) ? MAX_CODE_LEN
                                                                       : hctbp_pkg::WORD_W;

  hctbp_pkg::cmd_t    cmd;
  hctbp_pkg::status_t status;

  logic [hctbp_pkg::SYM_W-1:0]    symbol;
  logic [hctbp_pkg::WORD_W-1:0]   code_word;
  logic [hctbp_pkg::LEN_IN_W-1:0] code_length;

  // Unpack input fields
  assign symbol      = s_axis_tdata[7:0];
  assign code_word   = s_axis_tdata[39:8];
  assign code_length = s_axis_tdata[45:40];

  hctbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hctbp_datapath #(
    .LenLimit    (LenLimit),
    .SymbolCount (SYMBOL_COUNT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .symbol_i      (symbol),
    .code_word_i   (code_word),
    .code_length_i (code_length),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

  // Checks
  `HCTBP_ASSERT_IMP(a_emit_needs_slot, cmd.emit, status.slot_free && status.byte_ready)
  `HCTBP_ASSERT_NXT(a_emit_shows_out, cmd.emit, m_axis_tvalid)
  `HCTBP_ASSERT_IMP(a_idle_no_work, s_axis_tready, !(cmd.emit || cmd.merge || cmd.commit))
  `HCTBP_ASSERT_NXT(a_lookup_then_merge, cmd.lookup, cmd.merge)

endmodule

FILE: verif/hctbp_stream_checker.sv
`timescale 1ns / 1ps

module hctbp_stream_checker
  import hctbp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // symbol [7:0], code_word [39:8], code_length [45:40], zero [47:46]
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // action [1:0]
  input  logic [ACT_W-1:0]     s_axis_tuser,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // out_byte [7:0]
  input  logic [BYTE_W-1:0]    m_axis_tdata,
  input  logic                 m_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   bytes_o
);

  localparam int unsigned LEN_LIMIT   = 32;
  localparam int unsigned TABLE_DEPTH = 256;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  // Shadow code table and bit accumulator
  logic [WORD_W-1:0]   code_word_q [TABLE_DEPTH];
  logic [LEN_IN_W-1:0] code_len_q  [TABLE_DEPTH];
  logic [PEND_W-1:0]   pend_bits_q;
  logic [PCNT_W-1:0]   pend_cnt_q;
  packed_byte_t        byte_q [$];
  int                  fails = 0;
  int                  seen  = 0;

  task automatic note_fail(input string msg);
    if (fails < 10) $display("%0t mismatch: %s", $time, msg);
    fails++;
  endtask

  // Apply one input transfer to the shadow state and queue the bytes it produces
  task automatic pack_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                           input logic [WORD_W-1:0] word, input logic [LEN_IN_W-1:0] len);
    logic [LEN_IN_W-1:0] n;
    logic [WORK_W-1:0]   acc;
    logic [63:0]         mask;
    int unsigned         total;
    packed_byte_t        b;
    case (act)
      ACT_LOAD: begin
        // long lengths clamp to the code word width, upper code bits dropped
        n = (len > LEN_LIMIT) ? LEN_IN_W'(LEN_LIMIT) : len;
        mask = (64'd1 << n) - 64'd1;
        code_word_q[sym] = word & mask[WORD_W-1:0];
        code_len_q[sym]  = n;
      end
      ACT_ENCODE: begin
        n = code_len_q[sym];
        if (n != 0) begin
          acc   = (WORK_W'(pend_bits_q) << n) | WORK_W'(code_word_q[sym]);
          total = pend_cnt_q + n;
          while (total >= 8) begin
            total -= 8;
            b.data = BYTE_W'(acc >> total);
            b.last = (total < 8);
            byte_q.push_back(b);
          end
          mask = (64'd1 << total) - 64'd1;
          pend_bits_q = PEND_W'(acc & mask[WORK_W-1:0]);
          pend_cnt_q  = PCNT_W'(total);
        end
      end
      ACT_FLUSH: begin
        // leftover bits go out left-aligned, zero padded
        if (pend_cnt_q != 0) begin
          b.data = BYTE_W'({1'b0, pend_bits_q}) << (8 - pend_cnt_q);
          b.last = 1'b1;
          byte_q.push_back(b);
          pend_bits_q = '0;
          pend_cnt_q  = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Compare output transfers, then predict from input transfers
  always @(posedge clk_i or negedge rst_ni) begin
    packed_byte_t want;
    if (!rst_ni) begin
      pend_bits_q = '0;
      pend_cnt_q  = '0;
      byte_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen++;
        if (byte_q.size() == 0) begin
          note_fail($sformatf("unexpected byte %02h last %0b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = byte_q.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tlast !== want.last)
            note_fail($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                                seen, want.data, want.last, m_axis_tdata, m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pack_item(s_axis_tuser, s_axis_tdata[SYM_W-1:0], s_axis_tdata[SYM_W +: WORD_W],
                  s_axis_tdata[SYM_W+WORD_W +: LEN_IN_W]);
    end
    fail_count_o <= fails;
    pending_o    <= byte_q.size();
    bytes_o      <= seen;
  end

endmodule

FILE: verif/tb_huffman_code_table_bit_packer.sv
`timescale 1ns / 1ps

module tb_huffman_code_table_bit_packer;
  import hctbp_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 228;
  localparam int unsigned CALM_FROM    = 190;
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
  logic [ACT_W-1:0]     s_axis_tuser  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [BYTE_W-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;

  int fail_count;
  int pending_bytes;
  int bytes_checked;

  // Stimulus bookkeeping
  bit               calm      = 1'b0;
  bit               hold_done = 1'b0;
  int               counted   = 0;
  bit               loaded [256];
  logic [SYM_W-1:0] loaded_syms [$];
  int               n_load, n_encode, n_flush, n_ignored;

  always #4 clk_i = ~clk_i;

  huffman_code_table_bit_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  hctbp_stream_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .fail_count_o  (fail_count),
    .pending_o     (pending_bytes),
    .bytes_o       (bytes_checked)
  );

  // Offer one item, wait for its transfer, then maybe idle for a burst
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                           input logic [WORD_W-1:0] word, input logic [LEN_IN_W-1:0] len);
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, len, word, sym};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    case (act)
      ACT_LOAD:   n_load++;
      ACT_ENCODE: n_encode++;
      ACT_FLUSH:  n_flush++;
      default:    n_ignored++;
    endcase
    if (act == ACT_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Output side: random stalls, one long hold-off so the block backs up
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!hold_done && counted >= HOLD_AT) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout: transfers stopped before the run completed");
    $display("FAIL");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int unsigned         roll;
    int unsigned         pick;
    logic [LEN_IN_W-1:0] len;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: table extremes, then encodes that walk the accumulator
    send_item(ACT_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd1);   // upper code bits ignored
    send_item(ACT_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
    send_item(ACT_LOAD, 8'h80, 32'h1234_5678, 6'd0);   // zero-length entry
    send_item(ACT_LOAD, 8'h55, 32'hA5A5_A5A5, 6'h3F);  // clamps to 32 bits
    send_item(ACT_LOAD, 8'h2A, 32'h0000_0005, 6'd3);
    send_item(ACT_LOAD, 8'h7F, 32'h0000_0000, 6'd7);
    send_item(ACT_FLUSH, SYM_W'($urandom), $urandom, LEN_IN_W'($urandom));  // nothing pending
    send_item(ACT_ENCODE, 8'h80, $urandom, LEN_IN_W'($urandom));
    send_item(ACT_ENCODE, 8'h00, $urandom, LEN_IN_W'($urandom));
    send_item(ACT_ENCODE, 8'h7F, $urandom, LEN_IN_W'($urandom));  // exactly one byte
    send_item(ACT_ENCODE, 8'h2A, $urandom, LEN_IN_W'($urandom));
    send_item(ACT_ENCODE, 8'hFF, $urandom, LEN_IN_W'($urandom));  // four bytes out
    send_item(ACT_ENCODE, 8'h2A, $urandom, LEN_IN_W'($urandom));
    send_item(ACT_ENCODE, 8'h55, $urandom, LEN_IN_W'($urandom));
    send_item(ACT_ENCODE, 8'h00, $urandom, LEN_IN_W'($urandom));  // seven bits pending
    send_item(ACT_FLUSH, SYM_W'($urandom), $urandom, LEN_IN_W'($urandom));
    send_item(ACT_UNUSED, SYM_W'($urandom), $urandom, LEN_IN_W'($urandom));
    send_item(ACT_ENCODE, 8'h00, $urandom, LEN_IN_W'($urandom));
    send_item(ACT_FLUSH, SYM_W'($urandom), $urandom, LEN_IN_W'($urandom));  // single bit
    send_item(ACT_LOAD, 8'hFF, 32'h0000_0000, 6'd32);  // overwrite with all zeros
    send_item(ACT_ENCODE, 8'hFF, $urandom, LEN_IN_W'($urandom));
    send_item(ACT_ENCODE, 8'h2A, $urandom, LEN_IN_W'($urandom));
    send_item(ACT_FLUSH, SYM_W'($urandom), $urandom, LEN_IN_W'($urandom));

    // Random: mostly encodes of loaded symbols, table updates along the way
    while (counted < RANDOM_ITEMS) begin
      calm = (counted >= CALM_FROM);
      roll = $urandom_range(0, 99);
      if (loaded_syms.size() == 0 || roll < 22) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      len = LEN_IN_W'($urandom_range(1, 12));
        else if (pick < 85) len = LEN_IN_W'($urandom_range(13, 32));
        else if (pick < 93) len = LEN_IN_W'($urandom_range(33, 63));
        else                len = '0;
        send_item(ACT_LOAD, SYM_W'($urandom), $urandom, len);
        counted++;
      end else if (roll < 84) begin
        send_item(ACT_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                  $urandom, LEN_IN_W'($urandom));
        counted++;
      end else if (roll < 96) begin
        send_item(ACT_FLUSH, SYM_W'($urandom), $urandom, LEN_IN_W'($urandom));
        counted++;
      end else begin
        send_item(ACT_UNUSED, SYM_W'($urandom), $urandom, LEN_IN_W'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then give any stray output time to show up
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d loads, %0d encodes, %0d flushes, %0d ignored actions",
             n_load, n_encode, n_flush, n_ignored);
    $display("%0d packed bytes compared, incl. a %0d-cycle output hold-off",
             bytes_checked, HOLD_CYCLES);
    if (pending_bytes != 0)
      $display("%0d expected bytes never arrived", pending_bytes);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/hctbp_pkg.sv
rtl/core/hctbp_ctrl.sv
rtl/core/hctbp_datapath.sv
rtl/core/huffman_code_table_bit_packer.sv
verif/hctbp_stream_checker.sv
verif/tb_huffman_code_table_bit_packer.sv
